/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the parser RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/trhp_pkg.sv */
// ---------------------------------------------------------------------------
// TLS record parser package
// Phase codes, status codes, queue word and result word types, phase tables.
// ---------------------------------------------------------------------------
package trhp_pkg;

    // Parse phase; the value doubles as the field code of the next byte
    typedef enum logic [4:0] {
        PH_RECTYPE  = 5'd0,
        PH_RECVER   = 5'd1,
        PH_RECLEN   = 5'd2,
        PH_HSTYPE   = 5'd3,
        PH_HSLEN    = 5'd4,
        PH_HELLOVER = 5'd5,
        PH_RANDOM   = 5'd6,
        PH_SIDLEN   = 5'd7,
        PH_SID      = 5'd8,
        PH_CSLEN    = 5'd9,
        PH_CS       = 5'd10,
        PH_COMPLEN  = 5'd11,
        PH_COMP     = 5'd12,
        PH_EXTLEN   = 5'd13,
        PH_EXT      = 5'd14,
        PH_PMLEN    = 5'd15,
        PH_PM       = 5'd16,
        PH_SKIP     = 5'd17
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_CLOSED_MID = 2'd1,
        ST_REJECTED   = 2'd2,
        ST_OVERRUN    = 2'd3
    } status_t;

    localparam logic [7:0]  REC_HANDSHAKE      = 8'd22;
    localparam logic [7:0]  MSG_CLIENT_HELLO   = 8'd1;
    localparam logic [7:0]  MSG_SERVER_HELLO   = 8'd2;
    localparam logic [7:0]  MSG_CLIENT_KEY_EXC = 8'd16;
    localparam logic [15:0] RANDOM_BYTES       = 16'd32;

    // Word held in the queue between front and back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_closed;
    } in_item_t;

    // Result word
    typedef struct packed {
        phase_t      field_code;
        logic [23:0] field_value;
        logic        field_complete;
        logic        record_last;
        status_t     status;
    } result_t;

    // Bytes in the numeric field of a phase; zero for span and skip phases
    function automatic logic [1:0] field_width(input phase_t ph);
        logic [1:0] w;
        unique case (ph)
            PH_RECTYPE, PH_HSTYPE, PH_SIDLEN, PH_COMPLEN:         w = 2'd1;
            PH_RECVER, PH_RECLEN, PH_HELLOVER, PH_CSLEN,
            PH_EXTLEN, PH_PMLEN:                                  w = 2'd2;
            PH_HSLEN:                                             w = 2'd3;
            default:                                              w = 2'd0;
        endcase
        return w;
    endfunction

    // Phase that follows a finished span
    function automatic phase_t after_span(input phase_t ph);
        phase_t n;
        unique case (ph)
            PH_RANDOM: n = PH_SIDLEN;
            PH_SID:    n = PH_CSLEN;
            PH_CS:     n = PH_COMPLEN;
            PH_COMP:   n = PH_EXTLEN;
            default:   n = PH_SKIP;
        endcase
        return n;
    endfunction

endpackage

/* sv/trhp_queue.sv */
// ---------------------------------------------------------------------------
// TLS record parser queue
// Two-word queue between the accepting front and the parsing back end.
// ---------------------------------------------------------------------------
module trhp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  trhp_pkg::in_item_t push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output trhp_pkg::in_item_t pop_item
);
    import trhp_pkg::*;

    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    // Handshake on both sides
    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/trhp_parser.sv */
// ---------------------------------------------------------------------------
// TLS record parser back end
// Byte-wise record and handshake header state machine with result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trhp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  trhp_pkg::in_item_t in_item,
    output logic               res_valid,
    input  logic               res_ready,
    output trhp_pkg::result_t  res_word
);
    import trhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [23:0] acc_reg, acc_next;
    logic [15:0] rec_left_reg, rec_left_next;
    logic [15:0] span_left_reg, span_left_next;
    logic [7:0]  rec_kind_reg, rec_kind_next;
    logic [7:0]  msg_kind_reg, msg_kind_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        take;
    logic [1:0]  width;
    logic [1:0]  count_inc;
    logic [23:0] acc_shift;
    logic [15:0] rec_dec;
    logic [15:0] span_dec;
    logic        body;
    logic        gen;
    result_t     res;
    phase_t      nxt;

    // Take a word when the result register is free or being drained
    assign take      = in_valid && (!out_valid_reg || res_ready);
    assign in_ready  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    assign width     = field_width(phase_reg);
    assign count_inc = count_reg + 2'd1;
    assign acc_shift = {acc_reg[15:0], in_item.data_byte};
    assign rec_dec   = rec_left_reg - 16'd1;
    assign span_dec  = span_left_reg - 16'd1;
    assign body      = (phase_reg != PH_RECTYPE) && (phase_reg != PH_RECVER)
                    && (phase_reg != PH_RECLEN);

    // Next state and result of one byte
    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        rec_left_next  = rec_left_reg;
        span_left_next = span_left_reg;
        rec_kind_next  = rec_kind_reg;
        msg_kind_next  = msg_kind_reg;
        nxt            = phase_reg;
        gen            = 1'b1;
        res.field_code     = phase_reg;
        res.field_value    = {16'd0, in_item.data_byte};
        res.field_complete = 1'b0;
        res.record_last    = 1'b0;
        res.status         = ST_OK;

        if (in_item.stream_closed) begin
            // Drop all state; report only a close inside a record
            gen            = (phase_reg != PH_RECTYPE);
            nxt            = PH_RECTYPE;
            count_next     = 2'd0;
            acc_next       = 24'd0;
            rec_left_next  = 16'd0;
            span_left_next = 16'd0;
            rec_kind_next  = 8'd0;
            msg_kind_next  = 8'd0;
            res.field_code  = PH_SKIP;
            res.field_value = 24'd0;
            res.status      = ST_CLOSED_MID;
        end else begin
            if (width != 2'd0) begin
                // Gather a big-endian numeric field
                acc_next        = acc_shift;
                count_next      = count_inc;
                res.field_value = acc_shift;
                if (count_inc == width) begin
                    res.field_complete = 1'b1;
                    count_next         = 2'd0;
                    acc_next           = 24'd0;
                    unique case (phase_reg)
                        PH_RECTYPE: begin
                            rec_kind_next = acc_shift[7:0];
                            nxt           = PH_RECVER;
                        end
                        PH_RECVER: nxt = PH_RECLEN;
                        PH_RECLEN: begin
                            rec_left_next = acc_shift[15:0];
                            nxt = (rec_kind_reg == REC_HANDSHAKE) ? PH_HSTYPE : PH_SKIP;
                            if (acc_shift[15:0] == 16'd0) begin
                                res.record_last = 1'b1;
                                if (rec_kind_reg == REC_HANDSHAKE) begin
                                    res.status = ST_OVERRUN;
                                end
                                nxt = PH_RECTYPE;
                            end
                        end
                        PH_HSTYPE: begin
                            msg_kind_next = acc_shift[7:0];
                            nxt           = PH_HSLEN;
                        end
                        PH_HSLEN: begin
                            if (msg_kind_reg == MSG_CLIENT_HELLO) begin
                                nxt = PH_HELLOVER;
                            end else if (msg_kind_reg == MSG_CLIENT_KEY_EXC) begin
                                nxt = PH_PMLEN;
                            end else begin
                                if (msg_kind_reg == MSG_SERVER_HELLO) begin
                                    res.status = ST_REJECTED;
                                end
                                nxt = PH_SKIP;
                            end
                        end
                        PH_HELLOVER: begin
                            span_left_next = RANDOM_BYTES;
                            nxt            = PH_RANDOM;
                        end
                        PH_SIDLEN, PH_CSLEN, PH_COMPLEN, PH_EXTLEN, PH_PMLEN: begin
                            // Open the span that the length announces
                            span_left_next = acc_shift[15:0];
                            if (acc_shift[15:0] != 16'd0) begin
                                nxt = phase_t'(phase_reg + 5'd1);
                            end else begin
                                nxt = after_span(phase_t'(phase_reg + 5'd1));
                            end
                        end
                        default: nxt = PH_SKIP;
                    endcase
                end
            end else if (phase_reg != PH_SKIP) begin
                // Count down a span
                span_left_next = span_dec;
                if (span_dec == 16'd0) begin
                    nxt = after_span(phase_reg);
                end
            end

            // Count down the record body
            if (body) begin
                rec_left_next = rec_dec;
                if (rec_dec == 16'd0) begin
                    res.record_last = 1'b1;
                    if (nxt != PH_SKIP) begin
                        res.status = ST_OVERRUN;
                    end
                    nxt = PH_RECTYPE;
                end
            end

            if (nxt == PH_RECTYPE) begin
                count_next     = 2'd0;
                acc_next       = 24'd0;
                span_left_next = 16'd0;
            end
        end
        phase_next = nxt;

        // Load or drain the result register
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        if (take) begin
            out_valid_next = gen;
            out_next       = res;
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RECTYPE;
            count_reg     <= 2'd0;
            acc_reg       <= 24'd0;
            rec_left_reg  <= 16'd0;
            span_left_reg <= 16'd0;
            rec_kind_reg  <= 8'd0;
            msg_kind_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                acc_reg       <= acc_next;
                rec_left_reg  <= rec_left_next;
                span_left_reg <= span_left_next;
                rec_kind_reg  <= rec_kind_next;
                msg_kind_reg  <= msg_kind_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    `ASSERT_CLK(a_hdr_clean, aclk, aresetn,
        (phase_reg == PH_RECTYPE) |-> (count_reg == 2'd0 && acc_reg == 24'd0
            && span_left_reg == 16'd0), "header start with stale field state")
    `ASSERT_CLK(a_close_rewinds, aclk, aresetn,
        (take && in_item.stream_closed) |=> (phase_reg == PH_RECTYPE),
        "close did not rewind parser")
    `ASSERT_CLK(a_span_nonzero, aclk, aresetn,
        (phase_reg == PH_RANDOM || phase_reg == PH_SID || phase_reg == PH_CS
            || phase_reg == PH_COMP || phase_reg == PH_EXT || phase_reg == PH_PM)
            |-> (span_left_reg != 16'd0), "span phase with no bytes left")
    `ASSERT_CLK(a_close_word, aclk, aresetn,
        (out_valid_reg && out_reg.status == ST_CLOSED_MID) |-> (out_reg.field_code == PH_SKIP
            && !out_reg.record_last && !out_reg.field_complete), "malformed close result")
    `ASSERT_ALWAYS(a_count_range, aclk, !aresetn || (count_reg != 2'd3),
        "field byte count out of range")

endmodule

/* sv/tls_record_handshake_parser.sv */
// ---------------------------------------------------------------------------
// TLS record and handshake header parser
// Splits a received byte stream into tagged record and handshake fields.
// ---------------------------------------------------------------------------
// Channel  Ports            tdata (low bit up)                        tuser / tlast
// in       s_t*             data_byte[7:0]                            stream_closed
// out      m_t*             field_value[23:0], field_complete,        field_code[4:0]
//                           status[1:0], zero fill                    / record_last
//
// One byte per cycle sustained while m_tready is high; a byte is held in the two-word
// queue, then its result is held in the result register of the parser, where it is
// presented.
// A close at a record boundary yields no result.
// Reset is synchronous and clears all parser state at once; no clearing pass.
// The queue absorbs up to two words while the result side is stalled.
// ---------------------------------------------------------------------------
module tls_record_handshake_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [0:0]  s_tuser,   // stream_closed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // field_value[23:0], field_complete, status[1:0]
    output logic [4:0]  m_tuser,   // field_code[4:0]
    output logic        m_tlast    // record_last
);
    import trhp_pkg::*;

    in_item_t front_item;
    in_item_t back_item;
    logic     back_valid;
    logic     back_ready;
    result_t  res_word;

    // Classify the incoming word: carried byte or connection close
    always_comb begin
        front_item.stream_closed = s_tuser[0];
        front_item.data_byte     = s_tuser[0] ? 8'd0 : s_tdata;
    end

    trhp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    trhp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (back_valid),
        .in_ready  (back_ready),
        .in_item   (back_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_word  (res_word)
    );

    // Pack the result word
    assign m_tdata = {5'd0, res_word.status, res_word.field_complete, res_word.field_value};
    assign m_tuser = res_word.field_code;
    assign m_tlast = res_word.record_last;

endmodule

/* test/tls_record_handshake_parser_tb.sv */
// ---------------------------------------------------------------------------
// TLS record parser testbench
// Drives byte streams of TLS records into the parser: empty records, stream
// closes at and inside record boundaries, rejected ServerHello, then random
// ClientHello, ClientKeyExchange, unknown message and plain records with
// exact, padded and truncated lengths plus broken noise. A byte-level parser
// model predicts each result word, which is compared field by field with what
// the block sends. The sender idles in bursts and the receiver stalls on its
// own pattern, with long hold-offs that fill the block.
// ---------------------------------------------------------------------------
module tls_record_handshake_parser_tb;
    import trhp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned SPAN_CAP     = 48;

    // Non-handshake record types used as plain traffic
    localparam logic [7:0] REC_CHANGE_CIPHER = 8'd20;
    localparam logic [7:0] REC_ALERT         = 8'd21;
    localparam logic [7:0] REC_APP_DATA      = 8'd23;

    // Bytes in the numeric field of each phase; zero for spans and skipped bytes
    localparam logic [1:0] NUMERIC_BYTES [18] = '{
        2'd1, 2'd2, 2'd2, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd0
    };

    typedef enum int {
        TK_CLIENT_HELLO, TK_KEY_EXCHANGE, TK_SERVER_HELLO,
        TK_OTHER_MESSAGE, TK_PLAIN_RECORD, TK_NOISE
    } traffic_kind_t;

    typedef enum int {LEN_EXACT, LEN_TRAILING, LEN_SHORT} rec_len_mode_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_THREE_OF_FOUR, RX_SPARSE} rx_style_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic [0:0]  s_tuser;   // stream_closed
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // field_value[23:0], field_complete, status[1:0], zero fill
    logic [4:0]  m_tuser;   // field_code[4:0]
    logic        m_tlast;   // record_last

    // Parser model state
    phase_t      prs_phase;
    logic [1:0]  prs_count;
    logic [23:0] prs_acc;
    logic [15:0] prs_rec_left;
    logic [15:0] prs_span_left;
    logic [7:0]  prs_rec_type;
    logic [7:0]  prs_msg_type;

    result_t     expected_results[$];
    logic [7:0]  body_bytes[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    bit          hold_request = 1'b0;

    tls_record_handshake_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_parser();
        prs_phase     = PH_RECTYPE;
        prs_count     = 2'd0;
        prs_acc       = 24'd0;
        prs_rec_left  = 16'd0;
        prs_span_left = 16'd0;
        prs_rec_type  = 8'd0;
        prs_msg_type  = 8'd0;
    endfunction

    function automatic phase_t span_successor(input phase_t ph);
        case (ph)
            PH_RANDOM: return PH_SIDLEN;
            PH_SID:    return PH_CSLEN;
            PH_CS:     return PH_COMPLEN;
            PH_COMP:   return PH_EXTLEN;
            default:   return PH_SKIP;
        endcase
    endfunction

    // Load a span counter; an empty span passes straight on
    function automatic phase_t enter_span(input phase_t span_ph, input logic [15:0] len);
        prs_span_left = len;
        return (len != 16'd0) ? span_ph : span_successor(span_ph);
    endfunction

    // Advance the model by one accepted word; return 1 when it yields a result
    function automatic bit predict_result(input logic [7:0] b, input logic closed,
                                          output result_t r);
        phase_t      ph;
        phase_t      nxt;
        logic [23:0] v;
        logic [23:0] value;
        logic        complete;
        logic        last;
        logic        in_body;
        logic        mid;
        status_t     st;
        ph       = prs_phase;
        nxt      = ph;
        value    = {16'd0, b};
        complete = 1'b0;
        last     = 1'b0;
        st       = ST_OK;
        in_body  = (ph >= PH_HSTYPE);
        r        = '0;

        // Close: report only when a record was under way
        if (closed) begin
            mid = (prs_phase != PH_RECTYPE);
            clear_parser();
            if (!mid)
                return 1'b0;
            r.field_code = PH_SKIP;
            r.status     = ST_CLOSED_MID;
            return 1'b1;
        end

        if (NUMERIC_BYTES[ph] != 2'd0) begin
            // Gather a big-endian numeric field
            prs_acc   = {prs_acc[15:0], b};
            prs_count = prs_count + 2'd1;
            value     = prs_acc;
            if (prs_count == NUMERIC_BYTES[ph]) begin
                v         = prs_acc;
                complete  = 1'b1;
                prs_count = 2'd0;
                prs_acc   = 24'd0;
                case (ph)
                    PH_RECTYPE: begin
                        prs_rec_type = v[7:0];
                        nxt = PH_RECVER;
                    end
                    PH_RECVER: nxt = PH_RECLEN;
                    PH_RECLEN: begin
                        prs_rec_left = v[15:0];
                        nxt = (prs_rec_type == REC_HANDSHAKE) ? PH_HSTYPE : PH_SKIP;
                        if (prs_rec_left == 16'd0) begin
                            last = 1'b1;
                            if (prs_rec_type == REC_HANDSHAKE)
                                st = ST_OVERRUN;
                            nxt = PH_RECTYPE;
                        end
                    end
                    PH_HSTYPE: begin
                        prs_msg_type = v[7:0];
                        nxt = PH_HSLEN;
                    end
                    PH_HSLEN: begin
                        if (prs_msg_type == MSG_CLIENT_HELLO)
                            nxt = PH_HELLOVER;
                        else if (prs_msg_type == MSG_CLIENT_KEY_EXC)
                            nxt = PH_PMLEN;
                        else begin
                            if (prs_msg_type == MSG_SERVER_HELLO)
                                st = ST_REJECTED;
                            nxt = PH_SKIP;
                        end
                    end
                    PH_HELLOVER: begin
                        prs_span_left = RANDOM_BYTES;
                        nxt = PH_RANDOM;
                    end
                    PH_SIDLEN:  nxt = enter_span(PH_SID, v[15:0]);
                    PH_CSLEN:   nxt = enter_span(PH_CS, v[15:0]);
                    PH_COMPLEN: nxt = enter_span(PH_COMP, v[15:0]);
                    PH_EXTLEN:  nxt = enter_span(PH_EXT, v[15:0]);
                    PH_PMLEN:   nxt = enter_span(PH_PM, v[15:0]);
                    default:    nxt = PH_SKIP;
                endcase
            end
        end else if (ph != PH_SKIP) begin
            // Count down a span
            prs_span_left = prs_span_left - 16'd1;
            if (prs_span_left == 16'd0)
                nxt = span_successor(ph);
        end

        // Count down the record body; flag anything still outstanding at its end
        if (in_body) begin
            prs_rec_left = prs_rec_left - 16'd1;
            if (prs_rec_left == 16'd0) begin
                last = 1'b1;
                if (nxt != PH_SKIP)
                    st = ST_OVERRUN;
                nxt = PH_RECTYPE;
            end
        end

        if (nxt == PH_RECTYPE) begin
            prs_count     = 2'd0;
            prs_acc       = 24'd0;
            prs_span_left = 16'd0;
        end
        prs_phase = nxt;

        r.field_code     = ph;
        r.field_value    = value;
        r.field_complete = complete;
        r.record_last    = last;
        r.status         = st;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- sender

    // Offer one word, idling between bursts, and log its expected result
    task automatic send_word(input logic [7:0] b, input logic closed);
        result_t r;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= closed;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
        if (predict_result(b, closed, r))
            expected_results.push_back(r);
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] frame[$]);
        foreach (frame[i]) send_word(frame[i], 1'b0);
    endtask

    function automatic logic [15:0] pick_version();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return {8'h03, 8'($urandom_range(1, 4))};
    endfunction

    // Mostly short spans, some empty, a few at the field's maximum
    function automatic logic [15:0] pick_span_len(input logic [15:0] max_len);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: return 16'd0;
            18:            return max_len;
            19:            return 16'($urandom_range(0, max_len));
            default:       return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // Append a length prefix and its span; cap long spans, the record cuts them
    function automatic void push_span(input logic [15:0] len, input bit two_byte_len);
        int unsigned n;
        if (two_byte_len)
            body_bytes.push_back(len[15:8]);
        body_bytes.push_back(len[7:0]);
        n = (len > SPAN_CAP) ? SPAN_CAP : len;
        repeat (n) body_bytes.push_back(8'($urandom));
    endfunction

    function automatic void push_hs_head(input logic [7:0] msg);
        body_bytes.push_back(msg);
        repeat (3) body_bytes.push_back(8'($urandom));
    endfunction

    // Build one record of the given kind and send it, perhaps cut by a close
    task automatic send_record(input traffic_kind_t kind, input rec_len_mode_t mode,
                               input bit with_close);
        logic [7:0]  frame[$];
        logic [7:0]  msg;
        logic [7:0]  rec_type;
        logic [15:0] ver;
        logic [15:0] rec_len;
        int          close_at;
        body_bytes.delete();
        rec_type = REC_HANDSHAKE;
        case (kind)
            TK_CLIENT_HELLO: begin
                push_hs_head(MSG_CLIENT_HELLO);
                ver = pick_version();
                body_bytes.push_back(ver[15:8]);
                body_bytes.push_back(ver[7:0]);
                repeat (RANDOM_BYTES) body_bytes.push_back(8'($urandom));
                push_span(pick_span_len(16'h00FF), 1'b0);
                push_span(pick_span_len(16'hFFFF), 1'b1);
                push_span(pick_span_len(16'h00FF), 1'b0);
                push_span(pick_span_len(16'hFFFF), 1'b1);
            end
            TK_KEY_EXCHANGE: begin
                push_hs_head(MSG_CLIENT_KEY_EXC);
                push_span(pick_span_len(16'hFFFF), 1'b1);
            end
            TK_SERVER_HELLO: begin
                push_hs_head(MSG_SERVER_HELLO);
                repeat ($urandom_range(0, 12)) body_bytes.push_back(8'($urandom));
            end
            TK_OTHER_MESSAGE: begin
                do msg = 8'($urandom);
                while (msg == MSG_CLIENT_HELLO || msg == MSG_SERVER_HELLO ||
                       msg == MSG_CLIENT_KEY_EXC);
                push_hs_head(msg);
                repeat ($urandom_range(0, 12)) body_bytes.push_back(8'($urandom));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       rec_type = REC_CHANGE_CIPHER;
                    1:       rec_type = REC_ALERT;
                    2:       rec_type = REC_APP_DATA;
                    default: rec_type = 8'($urandom);
                endcase
                repeat ($urandom_range(0, 24)) body_bytes.push_back(8'($urandom));
            end
        endcase

        // Pick the declared body length against what was built
        case (mode)
            LEN_EXACT:    rec_len = 16'(body_bytes.size());
            LEN_TRAILING: rec_len = 16'(body_bytes.size() + $urandom_range(1, 6));
            default:      rec_len = (body_bytes.size() == 0) ? 16'd0 :
                                    16'($urandom_range(0, body_bytes.size() - 1));
        endcase

        ver = pick_version();
        frame.push_back(rec_type);
        frame.push_back(ver[15:8]);
        frame.push_back(ver[7:0]);
        frame.push_back(rec_len[15:8]);
        frame.push_back(rec_len[7:0]);
        for (int i = 0; i < rec_len; i++)
            frame.push_back((i < body_bytes.size()) ? body_bytes[i] : 8'($urandom));

        // A close may land before, inside or just after the record
        close_at = with_close ? int'($urandom_range(0, frame.size())) : -1;
        foreach (frame[i]) begin
            if (i == close_at)
                break;
            send_word(frame[i], 1'b0);
        end
        if (close_at >= 0)
            send_word(8'($urandom), 1'b1);
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin : result_drain
        int unsigned pace;
        rx_style_t   style;
        m_tready = 1'b0;
        pace     = 0;
        style    = RX_ALWAYS;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // Hold off for a long stretch so the block backs up
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (pace == 0) begin
                    style = rx_style_t'($urandom_range(0, 3));
                    pace  = $urandom_range(16, 96);
                end
                pace--;
                case (style)
                    RX_ALWAYS:        m_tready <= 1'b1;
                    RX_COIN:          m_tready <= 1'($urandom_range(0, 1));
                    RX_THREE_OF_FOUR: m_tready <= (pace % 4 != 0);
                    default:          m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checker

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    initial begin : result_check
        result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual code %0d value %0h",
                             $time, m_tuser, m_tdata[23:0]);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("field_code", 24'(want.field_code), 24'(m_tuser));
                    check_field("field_value", want.field_value, m_tdata[23:0]);
                    check_field("field_complete", 24'(want.field_complete),
                                24'(m_tdata[24]));
                    check_field("status", 24'(want.status), 24'(m_tdata[26:25]));
                    check_field("record_last", 24'(want.record_last), 24'(m_tlast));
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Empty bodies: a handshake one is an overrun, a plain one is not
    task automatic test_empty_records();
        logic [7:0] seq[$];
        seq = '{REC_HANDSHAKE, 8'h03, 8'h03, 8'h00, 8'h00,
                REC_APP_DATA, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame(seq);
    endtask

    // Close at a boundary is silent; inside a header it reports
    task automatic test_stream_close();
        logic [7:0] seq[$];
        send_word(8'hFF, 1'b1);
        seq = '{REC_HANDSHAKE, 8'h03};
        send_frame(seq);
        send_word(8'h00, 1'b1);
    endtask

    // ServerHello is rejected on its length, the rest is skipped
    task automatic test_server_hello();
        logic [7:0] seq[$];
        seq = '{REC_HANDSHAKE, 8'h03, 8'h03, 8'h00, 8'h06,
                MSG_SERVER_HELLO, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
        send_frame(seq);
    endtask

    // Stall the receiver for a long stretch while a full record is offered
    task automatic test_backpressure();
        hold_request = 1'b1;
        send_record(TK_CLIENT_HELLO, LEN_EXACT, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned   start;
        int unsigned   round;
        int unsigned   pick;
        traffic_kind_t kind;
        rec_len_mode_t mode;
        start = items_sent;
        round = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            // Open with one of each kind, then draw by weight
            if (round < 6)
                kind = traffic_kind_t'(round);
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 35)      kind = TK_CLIENT_HELLO;
                else if (pick < 55) kind = TK_KEY_EXCHANGE;
                else if (pick < 63) kind = TK_SERVER_HELLO;
                else if (pick < 71) kind = TK_OTHER_MESSAGE;
                else if (pick < 90) kind = TK_PLAIN_RECORD;
                else                kind = TK_NOISE;
            end
            case ($urandom_range(0, 3))
                0, 1:    mode = LEN_EXACT;
                2:       mode = LEN_TRAILING;
                default: mode = LEN_SHORT;
            endcase
            if ($urandom_range(0, 49) == 0)
                hold_request = 1'b1;
            if (kind == TK_NOISE) begin
                // Random bytes, then a close to realign
                repeat ($urandom_range(1, 12)) send_word(8'($urandom), 1'b0);
                send_word(8'($urandom), 1'b1);
            end else begin
                send_record(kind, mode, $urandom_range(0, 9) == 0);
            end
            round++;
        end
    endtask

    // ---------------------------------------------------------------- run

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : run_tests
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = 1'b0;
        clear_parser();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_records();
        test_stream_close();
        test_server_hello();
        test_backpressure();
        test_random_traffic();
        s_tvalid <= 1'b0;

        // Drain outstanding words, then watch for strays
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
